/* rtl/core/rhht_pkg.sv */
// ----------------------------------------------------------------------------
// rhht_pkg
// shared types and constants of the robin hood hash table
// ----------------------------------------------------------------------------
package rhht_pkg;

    localparam logic [7:0] TAG_OCCUPIED  = 8'h80;
    localparam logic [7:0] TAG_HASH_MASK = 8'h7f;
    localparam logic [7:0] PSL_MAX       = 8'hff;

    localparam int STATUS_BITS = 3;
    localparam int SLOT_BITS   = 6;
    localparam int OCC_BITS    = 7;

    localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_REPLACED  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic REG_MULTIMAP  = 1'b0;
    localparam logic REG_MAX_ITEMS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_DECIDE,
        S_PLACE_RD,
        S_PLACE_CMP,
        S_OUT
    } t_state;

endpackage

/* rtl/core/rhht_if.sv */
// ----------------------------------------------------------------------------
// rhht_req_if / rhht_rsp_if / rhht_cfg_if
// valid-ready channels of the hash table
// ----------------------------------------------------------------------------
interface rhht_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] key;
    logic [31:0] key_hash;
    logic [63:0] value;
    modport source (output valid, operation, key, key_hash, value, input ready);
    modport sink   (input valid, operation, key, key_hash, value, output ready);
endinterface

interface rhht_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [63:0] found_value;
    logic [6:0]  occupancy;
    modport source (output valid, status, slot, found_value, occupancy, input ready);
    modport sink   (input valid, status, slot, found_value, occupancy, output ready);
endinterface

interface rhht_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [6:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/robin_hood_hash_table.sv */
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// open-addressed robin hood hash table with a sequential probe walker
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one transaction per operation: search or insert of a
//   key with its hash and value. rsp channel returns exactly one transaction
//   per request: status, slot, value at the slot and item count.
//   cfg channel writes multimap_mode (index 0) and max_items (index 1); write
//   only while no request is in flight.
// probing:
//   one slot memory port is shared by all probing; each probed slot takes a
//   read state and then a compare/write state. an operation runs find probes
//   (skipped by a multimap insert), a decide step, place probes (inserts
//   only) and an output step. the block takes one request at a time; req
//   ready is low while busy.
// reset:
//   synchronous active-low reset empties every slot at once through per-slot
//   valid bits, zeroes the item count and restores multimap_mode=0 and
//   max_items=48. no clearing pass is needed.
// stall:
//   the response is held in an output register until taken; the next request
//   is accepted in the same cycle the response is taken.
// ----------------------------------------------------------------------------
module robin_hood_hash_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 64,
    parameter int VALUE_BITS  = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rhht_req_if.sink   req,
    rhht_rsp_if.source rsp,
    rhht_cfg_if.sink   cfg
);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);

    rhht_pkg::t_state r_state, n_state;

    // configuration
    logic       r_multimap;
    logic [6:0] r_max_items;

    // latched request
    logic                r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [6:0]          r_hash_lo;
    logic [AW-1:0]       r_home;
    logic [VALUE_BITS-1:0] r_value;

    // walk state
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_placed, n_placed;
    logic [AW-1:0] r_landed, n_landed;
    logic [7:0]    r_ctag, n_ctag;
    logic [7:0]    r_cpsl, n_cpsl;
    logic [KEY_BITS-1:0]   r_ckey, n_ckey;
    logic [VALUE_BITS-1:0] r_cval, n_cval;
    logic          r_hit, n_hit;
    logic [AW-1:0] r_where, n_where;
    logic [CW-1:0] r_total, n_total;

    // response register
    logic                r_rsp_vld, n_rsp_vld;
    logic [2:0]          r_status, n_status;
    logic [5:0]          r_slot, n_slot;
    logic [VALUE_BITS-1:0] r_fv, n_fv;

    // memory port
    logic [AW-1:0]         m_addr;
    logic                  m_we, m_we_val;
    logic [7:0]            m_tag_w, m_psl_w, m_tag, m_psl;
    logic [KEY_BITS-1:0]   m_key_w, m_key;
    logic [VALUE_BITS-1:0] m_val_w, m_val;
    logic                  m_vld;
    logic [7:0]            new_tag;
    logic                  occ;

    rhht_slot_ram #(
        .DEPTH(TABLE_DEPTH), .KW(KEY_BITS), .VW(VALUE_BITS), .AW(AW)
    ) u_ram (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_addr(m_addr), .i_we(m_we),
        .i_tag(m_tag_w), .i_psl(m_psl_w), .i_key(m_key_w), .i_val(m_val_w),
        .i_we_val_only(m_we_val), .o_vld(m_vld),
        .o_tag(m_tag), .o_psl(m_psl), .o_key(m_key), .o_val(m_val)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (r_state == rhht_pkg::S_IDLE) && (!r_rsp_vld || rsp.ready);

    assign rsp.valid       = r_rsp_vld;
    assign rsp.status      = r_status;
    assign rsp.slot        = r_slot;
    assign rsp.found_value = 64'(r_fv);
    assign rsp.occupancy   = 7'(r_total);

    assign new_tag = rhht_pkg::TAG_OCCUPIED | {1'b0, r_hash_lo};
    // unwritten slots read back as empty through the valid bit
    assign occ     = m_vld && m_tag[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_multimap  <= 1'b0;
            r_max_items <= 7'd48;
        end else if (cfg.valid) begin
            case (cfg.index)
                rhht_pkg::REG_MULTIMAP:  r_multimap  <= cfg.data[0];
                rhht_pkg::REG_MAX_ITEMS: r_max_items <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rhht_pkg::S_IDLE;
            r_rsp_vld <= 1'b0;
            r_total   <= '0;
        end else begin
            r_state   <= n_state;
            r_rsp_vld <= n_rsp_vld;
            r_total   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req.valid && req.ready) begin
            r_op      <= req.operation;
            r_key     <= req.key[KEY_BITS-1:0];
            r_hash_lo <= req.key_hash[6:0];
            r_home    <= req.key_hash[AW-1:0];
            r_value   <= req.value[VALUE_BITS-1:0];
        end
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_placed <= n_placed;
        r_landed <= n_landed;
        r_ctag   <= n_ctag;
        r_cpsl   <= n_cpsl;
        r_ckey   <= n_ckey;
        r_cval   <= n_cval;
        r_hit    <= n_hit;
        r_where  <= n_where;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_fv     <= n_fv;
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_placed = r_placed;
        n_landed = r_landed;
        n_ctag   = r_ctag;
        n_cpsl   = r_cpsl;
        n_ckey   = r_ckey;
        n_cval   = r_cval;
        n_hit    = r_hit;
        n_where  = r_where;
        n_total  = r_total;
        n_status = r_status;
        n_slot   = r_slot;
        n_fv     = r_fv;
        n_rsp_vld = r_rsp_vld && !rsp.ready;
        m_addr   = r_idx;
        m_we     = 1'b0;
        m_we_val = 1'b0;
        m_tag_w  = r_ctag;
        m_psl_w  = r_cpsl;
        m_key_w  = r_ckey;
        m_val_w  = r_cval;
        case (r_state)
            rhht_pkg::S_IDLE: begin
                if (req.valid && req.ready) begin
                    n_idx   = req.key_hash[AW-1:0];
                    n_cnt   = '0;
                    n_hit   = 1'b0;
                    n_where = '0;
                    // multimap insert skips the key search
                    n_state = (req.operation == rhht_pkg::OP_INSERT && r_multimap)
                              ? rhht_pkg::S_DECIDE : rhht_pkg::S_FIND_RD;
                end
            end
            rhht_pkg::S_FIND_RD: begin
                n_state = rhht_pkg::S_FIND_CMP;
            end
            rhht_pkg::S_FIND_CMP: begin
                if (!occ) begin
                    n_state = rhht_pkg::S_DECIDE;
                end else if (m_tag == new_tag && m_key == r_key) begin
                    n_hit   = 1'b1;
                    n_where = r_idx;
                    n_fv    = m_val;
                    n_state = rhht_pkg::S_DECIDE;
                end else if (r_cnt == CW'(TABLE_DEPTH - 1)) begin
                    n_state = rhht_pkg::S_DECIDE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_state = rhht_pkg::S_FIND_RD;
                end
            end
            rhht_pkg::S_DECIDE: begin
                n_state = rhht_pkg::S_OUT;
                if (r_op == rhht_pkg::OP_SEARCH) begin
                    n_status = r_hit ? rhht_pkg::ST_FOUND : rhht_pkg::ST_NOT_FOUND;
                    n_slot   = 6'(r_where);
                    if (!r_hit) n_fv = '0;
                end else if (r_hit && !r_multimap) begin
                    m_addr   = r_where;
                    m_we_val = 1'b1;
                    m_val_w  = r_value;
                    n_status = rhht_pkg::ST_REPLACED;
                    n_slot   = 6'(r_where);
                    n_fv     = r_value;
                end else if ({1'b0, r_total} >= (CW+1)'(r_max_items)
                             || r_total >= CW'(TABLE_DEPTH)) begin
                    n_status = rhht_pkg::ST_FULL;
                    n_slot   = '0;
                    n_fv     = '0;
                end else begin
                    n_idx    = r_home;
                    n_landed = r_home;
                    n_placed = 1'b0;
                    n_ctag   = new_tag;
                    n_cpsl   = '0;
                    n_ckey   = r_key;
                    n_cval   = r_value;
                    n_status = rhht_pkg::ST_INSERTED;
                    n_fv     = r_value;
                    n_state  = rhht_pkg::S_PLACE_RD;
                end
            end
            rhht_pkg::S_PLACE_RD: begin
                n_state = rhht_pkg::S_PLACE_CMP;
            end
            rhht_pkg::S_PLACE_CMP: begin
                if (!occ) begin
                    m_we    = 1'b1;
                    n_slot  = 6'(r_placed ? r_landed : r_idx);
                    n_total = r_total + 1'b1;
                    n_state = rhht_pkg::S_OUT;
                end else begin
                    if (r_cpsl > m_psl) begin
                        m_we   = 1'b1;
                        n_ctag = m_tag;
                        n_ckey = m_key;
                        n_cval = m_val;
                        n_cpsl = (m_psl != rhht_pkg::PSL_MAX) ? m_psl + 8'd1 : m_psl;
                        if (!r_placed) begin
                            n_landed = r_idx;
                            n_placed = 1'b1;
                        end
                    end else begin
                        n_cpsl = (r_cpsl != rhht_pkg::PSL_MAX) ? r_cpsl + 8'd1 : r_cpsl;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = rhht_pkg::S_PLACE_RD;
                end
            end
            rhht_pkg::S_OUT: begin
                if (!r_rsp_vld || rsp.ready) begin
                    n_rsp_vld = 1'b1;
                    n_state   = rhht_pkg::S_IDLE;
                end
            end
            default: n_state = rhht_pkg::S_IDLE;
        endcase
    end
endmodule

/* rtl/core/rhht_slot_ram.sv */
// ----------------------------------------------------------------------------
// rhht_slot_ram
// slot storage: tag and probe length with valid bits, key and value memories
// ----------------------------------------------------------------------------
module rhht_slot_ram #(
    parameter int DEPTH = 64,
    parameter int KW    = 64,
    parameter int VW    = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_addr,
    input  logic          i_we,
    input  logic [7:0]    i_tag,
    input  logic [7:0]    i_psl,
    input  logic [KW-1:0] i_key,
    input  logic [VW-1:0] i_val,
    input  logic          i_we_val_only,
    output logic          o_vld,
    output logic [7:0]    o_tag,
    output logic [7:0]    o_psl,
    output logic [KW-1:0] o_key,
    output logic [VW-1:0] o_val
);
    // tag array is small enough for valid bits; an entry not valid reads empty
    logic [7:0]    mem_tag [DEPTH];
    logic [7:0]    mem_psl [DEPTH];
    logic [KW-1:0] mem_key [DEPTH];
    logic [VW-1:0] mem_val [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic          r_rd_vld;

    assign o_vld = r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_tag[i_addr] <= i_tag;
            mem_psl[i_addr] <= i_psl;
            mem_key[i_addr] <= i_key;
        end
        if (i_we || i_we_val_only) begin
            mem_val[i_addr] <= i_val;
        end
        r_rd_vld <= r_vld[i_addr];
        o_tag    <= mem_tag[i_addr];
        o_psl    <= mem_psl[i_addr];
        o_key    <= mem_key[i_addr];
        o_val    <= mem_val[i_addr];
    end
endmodule

/* rtl/core/rhht_checker.sv */
// ----------------------------------------------------------------------------
// rhht_checker
// port-level checks of the hash table
// ----------------------------------------------------------------------------
module rhht_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [2:0] i_status,
    input logic [6:0] i_occupancy
);
    // one request at a time: no accept while a response is being built
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while busy");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status <= rhht_pkg::ST_FULL))
        else $error("bad status");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_status)))
        else $error("response dropped");

    // a new response that is not an insert leaves occupancy unchanged
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !$past(i_rsp_valid) && i_status != rhht_pkg::ST_INSERTED
         && $past(i_rst_n)) |-> (i_occupancy == $past(i_occupancy)))
        else $error("occupancy changed without insert");
endmodule

bind robin_hood_hash_table rhht_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(req.valid), .i_req_ready(req.ready),
    .i_rsp_valid(rsp.valid), .i_rsp_ready(rsp.ready),
    .i_status(rsp.status), .i_occupancy(rsp.occupancy)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the robin hood hash table: a queue-fed driver and a
// response monitor, with an in-bench table model that predicts every response
// ----------------------------------------------------------------------------
module tb;

    // idle modes of the two sides
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;

    localparam int DEPTH       = 64;
    localparam int POOL_SIZE   = 96;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        operation;
        logic [63:0] key;
        logic [31:0] key_hash;
        logic [63:0] value;
    } t_lookup_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [63:0] found_value;
        logic [6:0]  occupancy;
    } t_lookup_rsp;

    logic i_clk;
    logic i_rst_n;

    rhht_req_if req ();
    rhht_rsp_if rsp ();
    rhht_cfg_if cfg ();

    robin_hood_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .req     (req),
        .rsp     (rsp),
        .cfg     (cfg)
    );

    // shadow copy of the table contents and registers
    logic [7:0]  tbl_tag  [DEPTH];
    logic [7:0]  tbl_dist [DEPTH];
    logic [63:0] tbl_key  [DEPTH];
    logic [63:0] tbl_val  [DEPTH];
    int unsigned model_total;
    logic        multimap_on;
    logic [6:0]  item_cap;

    t_lookup_req pending_ops[$];
    t_lookup_rsp expected_rsps[$];

    // key pool so that searches hit and inserts replace
    logic [63:0] pool_key  [POOL_SIZE];
    logic [31:0] pool_hash [POOL_SIZE];

    int  idle_mode;
    int  error_count;
    int  cycle_count;
    int  hold_left;
    bit  hold_go;
    bit  hold_done;

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------

    // walk from home while occupied; match on tag then key
    function automatic bit locate_key(input logic [63:0] key, input logic [31:0] hash,
                                      output int where);
        logic [7:0] tag;
        int         idx;
        tag   = rhht_pkg::TAG_OCCUPIED | (hash[7:0] & rhht_pkg::TAG_HASH_MASK);
        idx   = hash % DEPTH;
        where = 0;
        for (int n = 0; n < DEPTH; n++) begin
            if (!tbl_tag[idx][7]) return 1'b0;
            if (tbl_tag[idx] == tag && tbl_key[idx] == key) begin
                where = idx;
                return 1'b1;
            end
            idx = (idx + 1) % DEPTH;
        end
        return 1'b0;
    endfunction

    // robin hood placement, returns the slot where the new item lands
    function automatic int place_item(input logic [63:0] key, input logic [31:0] hash,
                                      input logic [63:0] value);
        logic [7:0]  c_tag, t_tag, c_dist, t_dist;
        logic [63:0] c_key, c_val, t_key, t_val;
        int          idx, landed;
        bit          moved;
        c_tag  = rhht_pkg::TAG_OCCUPIED | (hash[7:0] & rhht_pkg::TAG_HASH_MASK);
        c_dist = 8'd0;
        c_key  = key;
        c_val  = value;
        idx    = hash % DEPTH;
        landed = idx;
        moved  = 1'b0;
        for (int n = 0; n < DEPTH; n++) begin
            if (!tbl_tag[idx][7]) begin
                tbl_tag[idx]  = c_tag;
                tbl_key[idx]  = c_key;
                tbl_val[idx]  = c_val;
                tbl_dist[idx] = c_dist;
                if (!moved) landed = idx;
                break;
            end
            if (c_dist > tbl_dist[idx]) begin
                t_tag = tbl_tag[idx];
                t_dist = tbl_dist[idx];
                t_key = tbl_key[idx];
                t_val = tbl_val[idx];
                tbl_tag[idx]  = c_tag;
                tbl_key[idx]  = c_key;
                tbl_val[idx]  = c_val;
                tbl_dist[idx] = c_dist;
                if (!moved) begin
                    landed = idx;
                    moved  = 1'b1;
                end
                c_tag  = t_tag;
                c_key  = t_key;
                c_val  = t_val;
                c_dist = t_dist;
            end
            if (c_dist != rhht_pkg::PSL_MAX) c_dist = c_dist + 8'd1;
            idx = (idx + 1) % DEPTH;
        end
        return landed;
    endfunction

    function automatic t_lookup_rsp apply_lookup(input t_lookup_req r);
        t_lookup_rsp res;
        int          where;
        res = '0;
        if (r.operation == rhht_pkg::OP_SEARCH) begin
            if (locate_key(r.key, r.key_hash, where)) begin
                res.status      = rhht_pkg::ST_FOUND;
                res.slot        = where[5:0];
                res.found_value = tbl_val[where];
            end else begin
                res.status = rhht_pkg::ST_NOT_FOUND;
            end
        end else if (!multimap_on && locate_key(r.key, r.key_hash, where)) begin
            tbl_val[where]  = r.value;
            res.status      = rhht_pkg::ST_REPLACED;
            res.slot        = where[5:0];
            res.found_value = r.value;
        end else if (model_total >= item_cap || model_total >= DEPTH) begin
            res.status = rhht_pkg::ST_FULL;
        end else begin
            where           = place_item(r.key, r.key_hash, r.value);
            model_total     = model_total + 1;
            res.status      = rhht_pkg::ST_INSERTED;
            res.slot        = where[5:0];
            res.found_value = r.value;
        end
        res.occupancy = model_total[6:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: offers the head of the pending queue, holds it until taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lookup_req item;
        if (!i_rst_n) begin
            req.valid <= 1'b0;
        end else begin
            if (req.valid && req.ready) begin
                // transaction accepted: predict now, in acceptance order
                item = pending_ops.pop_front();
                expected_rsps.push_back(apply_lookup(item));
            end
            if (!(req.valid && !req.ready)) begin
                // free to pick the next offer; maybe idle this cycle
                if (pending_ops.size() != 0 &&
                    !((idle_mode == IDLE_SENDER && $urandom_range(99) < 81) ||
                      (idle_mode == IDLE_BOTH && $urandom_range(99) < 24))) begin
                    req.valid     <= 1'b1;
                    req.operation <= pending_ops[0].operation;
                    req.key       <= pending_ops[0].key;
                    req.key_hash  <= pending_ops[0].key_hash;
                    req.value     <= pending_ops[0].value;
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each response transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lookup_rsp want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
                $error("unexpected response: status %0d slot %0d", rsp.status, rsp.slot);
                error_count = error_count + 1;
            end else begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, rsp.status);
                    error_count = error_count + 1;
                end
                if (rsp.slot !== want.slot) begin
                    $error("slot: expected %0d actual %0d", want.slot, rsp.slot);
                    error_count = error_count + 1;
                end
                if (rsp.found_value !== want.found_value) begin
                    $error("found_value: expected %h actual %h",
                           want.found_value, rsp.found_value);
                    error_count = error_count + 1;
                end
                if (rsp.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d actual %0d",
                           want.occupancy, rsp.occupancy);
                    error_count = error_count + 1;
                end
            end
        end
        if (hold_left != 0)
            rsp.ready <= 1'b0;
        else if (idle_mode == IDLE_RECV)
            rsp.ready <= ($urandom_range(99) >= 81);
        else if (idle_mode == IDLE_BOTH)
            rsp.ready <= ($urandom_range(99) >= 24);
        else
            rsp.ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_op(input logic op, input logic [63:0] key,
                           input logic [31:0] hash, input logic [63:0] value);
        t_lookup_req item;
        item.operation = op;
        item.key       = key;
        item.key_hash  = hash;
        item.value     = value;
        pending_ops.push_back(item);
    endtask

    // mostly pool keys with their own hash; the rest fresh keys, some
    // sharing a pool tag so the key compare decides
    task automatic push_random(input int count);
        int          pick;
        logic [63:0] key;
        logic [31:0] hash;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(POOL_SIZE - 1);
            if ($urandom_range(99) < 85) begin
                key  = pool_key[pick];
                hash = pool_hash[pick];
            end else begin
                key  = {$urandom, $urandom};
                hash = $urandom;
                if ($urandom_range(1)) hash[6:0] = pool_hash[pick][6:0];
            end
            push_op($urandom_range(99) < 45 ? rhht_pkg::OP_INSERT : rhht_pkg::OP_SEARCH,
                    key, hash, {$urandom, $urandom});
        end
    endtask

    // wait until every offered item is answered, then let the block settle
    task automatic drain();
        while (pending_ops.size() != 0 || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] data);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        if (idx == rhht_pkg::REG_MULTIMAP) multimap_on = data[0];
        else item_cap = data;
        cfg.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic mm, input logic [6:0] cap, input int mode,
                             input int count);
        drain();
        write_reg(rhht_pkg::REG_MULTIMAP, {6'd0, mm});
        write_reg(rhht_pkg::REG_MAX_ITEMS, cap);
        idle_mode = mode;
        push_random(count);
    endtask

    // ------------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        req.valid     = 1'b0;
        req.operation = rhht_pkg::OP_SEARCH;
        req.key       = '0;
        req.key_hash  = '0;
        req.value     = '0;
        rsp.ready     = 1'b0;
        cfg.valid     = 1'b0;
        cfg.index     = rhht_pkg::REG_MULTIMAP;
        cfg.data      = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_tag[i]  = '0;
            tbl_dist[i] = '0;
            tbl_key[i]  = '0;
            tbl_val[i]  = '0;
        end
        model_total = 0;
        multimap_on = 1'b0;
        item_cap    = 7'd48;
        idle_mode   = IDLE_NONE;
        error_count = 0;
        cycle_count = 0;
        hold_left   = 0;
        hold_go     = 1'b0;
        hold_done   = 1'b0;

        // pool hashes: a quarter share the tag of an earlier entry
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_key[i]  = {$urandom, $urandom};
            pool_hash[i] = $urandom;
            if (i > 0 && $urandom_range(3) == 0)
                pool_hash[i][6:0] = pool_hash[$urandom_range(i - 1)][6:0];
        end

        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, field extremes, replace, tag clash, home taken
        push_op(rhht_pkg::OP_SEARCH, 64'd0, 32'd0, 64'd0);
        push_op(rhht_pkg::OP_INSERT, 64'd0, 32'd0, 64'd0);
        push_op(rhht_pkg::OP_SEARCH, 64'd0, 32'd0, '1);
        push_op(rhht_pkg::OP_INSERT, '1, '1, '1);
        push_op(rhht_pkg::OP_SEARCH, '1, '1, 64'd0);
        push_op(rhht_pkg::OP_INSERT, '1, '1, 64'h0123_4567_89ab_cdef);
        push_op(rhht_pkg::OP_SEARCH, '1, '1, 64'd0);
        // same tag, different key, same home: second lands one slot on
        push_op(rhht_pkg::OP_INSERT, 64'h5, 32'h0000_0080, 64'h55);
        push_op(rhht_pkg::OP_INSERT, 64'h6, 32'h0000_0080, 64'h66);
        push_op(rhht_pkg::OP_SEARCH, 64'h6, 32'h0000_0080, 64'd0);
        // same key, wrong hash: tag differs so no hit
        push_op(rhht_pkg::OP_SEARCH, 64'h6, 32'h0000_0081, 64'd0);
        // cluster at home 1 so a richer resident is displaced
        push_op(rhht_pkg::OP_INSERT, 64'h7, 32'h0000_0001, 64'h77);
        push_op(rhht_pkg::OP_INSERT, 64'h8, 32'h0000_0002, 64'h88);
        push_op(rhht_pkg::OP_INSERT, 64'h9, 32'h0000_0001, 64'h99);
        push_op(rhht_pkg::OP_SEARCH, 64'h8, 32'h0000_0002, 64'd0);
        push_op(rhht_pkg::OP_SEARCH, 64'h9, 32'h0000_0001, 64'd0);
        push_op(rhht_pkg::OP_SEARCH, 64'hdead, 32'h0000_003f, 64'd0);

        // cap of one under multimap, below the items held: every insert is refused
        run_phase(1'b1, 7'd1, IDLE_NONE, 100);
        // the sender idles between offers most of the time
        run_phase(1'b0, 7'd20, IDLE_SENDER, 250);
        // receiver holds off long while requests keep coming
        drain();
        write_reg(rhht_pkg::REG_MULTIMAP, 7'd1);
        write_reg(rhht_pkg::REG_MAX_ITEMS, 7'd40);
        idle_mode = IDLE_RECV;
        hold_go   = 1'b1;
        push_random(250);
        run_phase(1'b0, 7'd0, IDLE_BOTH, 100);
        // fill to the brim: full walks and wraparound
        run_phase(1'b1, 7'd64, IDLE_NONE, 350);
        run_phase(1'b0, 7'd127, IDLE_BOTH, 300);
        run_phase(1'b1, 7'd64, IDLE_SENDER, 300);

        drain();
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
